FILE: rtl/double_ended_queue_with_delete_assert.svh
// Assertion macros used by the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_WITH_DELETE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_DELETE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define DEQD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define DEQD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/deqd_pkg.sv
// Shared types and request/status codes of the double-ended queue.
package deqd_pkg;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_PUSH_BACK  = 3'd0;
  localparam kind_t KIND_POP_BACK   = 3'd1;
  localparam kind_t KIND_PUSH_FRONT = 3'd2;
  localparam kind_t KIND_POP_FRONT  = 3'd3;
  localparam kind_t KIND_DELETE     = 3'd4;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_EMPTY     = 2'd1;
  localparam status_t STATUS_FULL      = 2'd2;
  localparam status_t STATUS_NOT_FOUND = 2'd3;

endpackage

FILE: rtl/deqd_ram.sv
// Simple dual-port entry store: one write port, one registered read port.
module deqd_ram #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/double_ended_queue_with_delete.sv
// Double-ended queue of DATA_WIDTH-bit words, DEPTH entries, held as a ring in one
// simple dual-port RAM (one write, one read a cycle, read data registered).
// Each request (kind in s_axis_tuser, word in s_axis_tdata) gives one response:
// popped word, status and the count left. Push back/front, and any unused kind,
// answer from the idle state; a pop answers from ST_POP, waiting on the RAM
// read. A delete reads the ring from the front one entry per cycle and, on a
// match, copies each later entry one place forward (a read and a write per
// cycle). Pushes on full, pops on empty and deletes without a match change
// nothing and are flagged. A new request is taken only when the sequencer is
// idle and the response register is free or being drained in the same cycle.
// No clearing pass: entries are only read after being written.
module double_ended_queue_with_delete #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  // request
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [deqd_pkg::VALUE_W-1:0]           s_axis_tdata,  // [31:0] value
  input  logic [deqd_pkg::KIND_W-1:0]            s_axis_tuser,  // [2:0] kind
  // response
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((deqd_pkg::VALUE_W + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0]
                                                 m_axis_tdata,  // popped, count, zero pad
  output logic [deqd_pkg::STATUS_W-1:0]          m_axis_tuser   // [1:0] status
);

  localparam int AW    = $clog2(DEPTH);        // ring index
  localparam int CW    = $clog2(DEPTH + 1);    // occupancy 0..DEPTH
  localparam int OW    = CW + 1;               // offset arithmetic headroom
  localparam int VW    = deqd_pkg::VALUE_W;
  localparam int OUT_W = ((VW + CW + 7) / 8) * 8;

  localparam logic [AW:0]   DEPTH_S  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_POP   = 2'd1;   // waiting on popped word
  localparam logic [1:0] ST_SCAN  = 2'd2;   // compare one entry a cycle
  localparam logic [1:0] ST_SHIFT = 2'd3;   // close the gap after a match

  // ring position of an offset from the front
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] h,
                                             input logic [AW-1:0] o);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, o};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  // control registers
  logic [1:0]    state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] occ, occ_next;
  logic          res_valid, res_valid_next;
  // payload registers
  logic [AW-1:0]           off, off_next;       // scan offset / shift destination
  logic [DATA_WIDTH-1:0]   word, word_next;     // word being searched for
  deqd_pkg::value_t        res_popped, res_popped_next;
  deqd_pkg::status_t       res_status, res_status_next;
  logic [CW-1:0]           res_count, res_count_next;

  // RAM port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  logic                     accept;
  deqd_pkg::kind_t          in_kind;
  logic [DATA_WIDTH+VW-1:0] in_ext;
  logic [DATA_WIDTH-1:0]    in_word;
  logic [DATA_WIDTH+VW-1:0] rd_ext;
  deqd_pkg::value_t         rd_popped;
  logic                     is_full, is_empty;
  logic [AW-1:0]            head_dec;
  logic [AW-1:0]            occ_lo, occ_m1;
  logic [OW-1:0]            off_p1, off_p2;

  // store only the low DATA_WIDTH bits; popped word is zero-extended
  assign in_kind   = s_axis_tuser;
  assign in_ext    = {{DATA_WIDTH{1'b0}}, s_axis_tdata};
  assign in_word   = in_ext[DATA_WIDTH-1:0];
  assign rd_ext    = {{VW{1'b0}}, mem_rdata};
  assign rd_popped = rd_ext[VW-1:0];

  assign is_full  = (occ == FULL_CNT);
  assign is_empty = (occ == '0);
  assign head_dec = (head == '0) ? LAST_IDX : head - AW'(1);
  assign occ_lo   = occ[AW-1:0];              // used only when not full
  assign occ_m1   = occ_lo - AW'(1);          // used only when not empty
  assign off_p1   = OW'(off) + OW'(1);
  assign off_p2   = OW'(off) + OW'(2);

  assign s_axis_tready = (state == ST_IDLE) && (!res_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next      = state;
    head_next       = head;
    occ_next        = occ;
    off_next        = off;
    word_next       = word;
    res_valid_next  = res_valid && !m_axis_tready;
    res_popped_next = res_popped;
    res_status_next = res_status;
    res_count_next  = res_count;
    mem_we          = 1'b0;
    mem_waddr       = head;
    mem_wdata       = in_word;
    mem_raddr       = head;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          word_next       = in_word;
          res_popped_next = '0;
          res_status_next = deqd_pkg::STATUS_OK;
          res_count_next  = occ;
          case (in_kind)
            deqd_pkg::KIND_PUSH_BACK: begin
              res_valid_next = 1'b1;
              if (is_full) begin
                res_status_next = deqd_pkg::STATUS_FULL;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = ring_pos(head, occ_lo);
                occ_next       = occ + CW'(1);
                res_count_next = occ + CW'(1);
              end
            end
            deqd_pkg::KIND_PUSH_FRONT: begin
              res_valid_next = 1'b1;
              if (is_full) begin
                res_status_next = deqd_pkg::STATUS_FULL;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = head_dec;
                head_next      = head_dec;
                occ_next       = occ + CW'(1);
                res_count_next = occ + CW'(1);
              end
            end
            deqd_pkg::KIND_POP_BACK: begin
              if (is_empty) begin
                res_valid_next  = 1'b1;
                res_status_next = deqd_pkg::STATUS_EMPTY;
              end else begin
                mem_raddr      = ring_pos(head, occ_m1);
                occ_next       = occ - CW'(1);
                res_count_next = occ - CW'(1);
                state_next     = ST_POP;
              end
            end
            deqd_pkg::KIND_POP_FRONT: begin
              if (is_empty) begin
                res_valid_next  = 1'b1;
                res_status_next = deqd_pkg::STATUS_EMPTY;
              end else begin
                mem_raddr      = head;
                head_next      = ring_pos(head, AW'(1));
                occ_next       = occ - CW'(1);
                res_count_next = occ - CW'(1);
                state_next     = ST_POP;
              end
            end
            deqd_pkg::KIND_DELETE: begin
              if (is_empty) begin
                res_valid_next  = 1'b1;
                res_status_next = deqd_pkg::STATUS_NOT_FOUND;
              end else begin
                mem_raddr  = head;
                off_next   = '0;
                state_next = ST_SCAN;
              end
            end
            default: begin
              res_valid_next = 1'b1;
            end
          endcase
        end
      end

      ST_POP: begin
        res_valid_next  = 1'b1;
        res_popped_next = rd_popped;
        state_next      = ST_IDLE;
      end

      ST_SCAN: begin
        // mem_rdata holds the entry at offset off
        if (mem_rdata == word) begin
          if (off_p1 < OW'(occ)) begin
            mem_raddr  = ring_pos(head, off_p1[AW-1:0]);
            state_next = ST_SHIFT;
          end else begin
            // match on the last entry: nothing to move
            occ_next       = occ - CW'(1);
            res_count_next = occ - CW'(1);
            res_valid_next = 1'b1;
            state_next     = ST_IDLE;
          end
        end else if (off_p1 < OW'(occ)) begin
          mem_raddr = ring_pos(head, off_p1[AW-1:0]);
          off_next  = off_p1[AW-1:0];
        end else begin
          res_status_next = deqd_pkg::STATUS_NOT_FOUND;
          res_valid_next  = 1'b1;
          state_next      = ST_IDLE;
        end
      end

      ST_SHIFT: begin
        // mem_rdata holds entry off+1; it moves down to off
        mem_we    = 1'b1;
        mem_waddr = ring_pos(head, off);
        mem_wdata = mem_rdata;
        if (off_p2 < OW'(occ)) begin
          mem_raddr = ring_pos(head, off_p2[AW-1:0]);
          off_next  = off_p1[AW-1:0];
        end else begin
          occ_next       = occ - CW'(1);
          res_count_next = occ - CW'(1);
          res_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      occ       <= occ_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    off        <= off_next;
    word       <= word_next;
    res_popped <= res_popped_next;
    res_status <= res_status_next;
    res_count  <= res_count_next;
  end

  deqd_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = OUT_W'({res_count, res_popped});
  assign m_axis_tuser  = res_status;

endmodule

FILE: rtl/deqd_checker.sv
// Port-level checks on the deque response stream, bound to the top level.
`include "double_ended_queue_with_delete_assert.svh"

module deqd_checker #(
  parameter int DEPTH = 64
) (
  input logic clk,
  input logic rst,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((deqd_pkg::VALUE_W + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input logic [deqd_pkg::STATUS_W-1:0] m_axis_tuser
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = deqd_pkg::VALUE_W;

  logic [VW-1:0] popped;
  logic [CW-1:0] count;

  assign popped = m_axis_tdata[VW-1:0];
  assign count  = m_axis_tdata[VW+CW-1:VW];

  `DEQD_ASSERT_NEXT(a_resp_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "response changed while stalled")
  `DEQD_ASSERT_NOW(a_count_max, m_axis_tvalid, count <= CW'(DEPTH), "count beyond depth")
  `DEQD_ASSERT_NOW(a_full_count, m_axis_tvalid && m_axis_tuser == deqd_pkg::STATUS_FULL, count == CW'(DEPTH), "push dropped while not full")
  `DEQD_ASSERT_NOW(a_empty_pop, m_axis_tvalid && m_axis_tuser == deqd_pkg::STATUS_EMPTY, count == '0 && popped == '0, "empty pop with data or entries")
  `DEQD_ASSERT_NOW(a_miss_pop, m_axis_tvalid && m_axis_tuser == deqd_pkg::STATUS_NOT_FOUND, popped == '0, "failed delete returned data")

endmodule

bind double_ended_queue_with_delete deqd_checker #(.DEPTH(DEPTH)) u_deqd_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for the bounded double-ended queue with delete-on-match.
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH    = 64;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int RESP_W   = ((deqd_pkg::VALUE_W + CNT_W + 7) / 8) * 8;
  localparam int N_RANDOM = 1450;
  // watchdog bound, covering the slowest legal run of all requests plus one long hold-off
  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_CYCLES = 400;
  // settle time after the last response, with a margin on top
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;

  typedef struct packed {
    deqd_pkg::kind_t  kind;
    deqd_pkg::value_t value;
  } req_t;

  typedef struct packed {
    deqd_pkg::value_t   popped;
    deqd_pkg::status_t  status;
    logic [CNT_W-1:0]   count;
  } resp_t;

  logic clk;
  logic rst = 1'b1;

  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [deqd_pkg::VALUE_W-1:0]  s_axis_tdata  = '0;  // [31:0] value
  logic [deqd_pkg::KIND_W-1:0]   s_axis_tuser  = '0;  // [2:0] kind
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [RESP_W-1:0]             m_axis_tdata;  // [31:0] popped, [38:32] count, [39] pad
  logic [deqd_pkg::STATUS_W-1:0] m_axis_tuser;  // [1:0] status

  double_ended_queue_with_delete #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (deqd_pkg::VALUE_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the ring, front pointer and fill level.
  // ---------------------------------------------------------------------------
  deqd_pkg::value_t dq_words [DEPTH];
  logic [5:0]       dq_front = '0;
  logic [CNT_W-1:0] dq_fill  = '0;

  function automatic resp_t predict_response(deqd_pkg::kind_t kind,
                                             deqd_pkg::value_t value);
    resp_t r;
    bit    found;
    int    hit;
    r.popped = '0;
    r.status = deqd_pkg::STATUS_OK;
    found    = 1'b0;
    hit      = 0;
    case (kind)
      deqd_pkg::KIND_PUSH_BACK: begin
        if (dq_fill == CNT_W'(DEPTH)) begin
          r.status = deqd_pkg::STATUS_FULL;
        end else begin
          dq_words[dq_front + 6'(dq_fill)] = value;
          dq_fill++;
        end
      end
      deqd_pkg::KIND_POP_BACK: begin
        if (dq_fill == 0) begin
          r.status = deqd_pkg::STATUS_EMPTY;
        end else begin
          dq_fill--;
          r.popped = dq_words[dq_front + 6'(dq_fill)];
        end
      end
      deqd_pkg::KIND_PUSH_FRONT: begin
        if (dq_fill == CNT_W'(DEPTH)) begin
          r.status = deqd_pkg::STATUS_FULL;
        end else begin
          dq_front--;
          dq_words[dq_front] = value;
          dq_fill++;
        end
      end
      deqd_pkg::KIND_POP_FRONT: begin
        if (dq_fill == 0) begin
          r.status = deqd_pkg::STATUS_EMPTY;
        end else begin
          r.popped = dq_words[dq_front];
          dq_front++;
          dq_fill--;
        end
      end
      deqd_pkg::KIND_DELETE: begin
        // first match counted from the front; later entries close the gap
        for (int i = 0; i < dq_fill; i++) begin
          if (!found && dq_words[dq_front + 6'(i)] == value) begin
            found = 1'b1;
            hit   = i;
          end
        end
        if (!found) begin
          r.status = deqd_pkg::STATUS_NOT_FOUND;
        end else begin
          for (int j = hit; j + 1 < dq_fill; j++)
            dq_words[dq_front + 6'(j)] = dq_words[dq_front + 6'(j + 1)];
          dq_fill--;
        end
      end
      default: ;  // unused kinds: no operation
    endcase
    r.count = dq_fill;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  req_t  req_pending [$];
  resp_t resp_due    [$];

  // values that repeat often, so deletes find matches and duplicates exist
  deqd_pkg::value_t value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                       32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                                       32'hAAAA_AAAA, 32'h0000_FFFF};

  function automatic deqd_pkg::value_t pick_value(int pool_weight);
    if ($urandom_range(0, 3) < pool_weight)
      return value_pool[$urandom_range(0, 7)];
    return deqd_pkg::value_t'($urandom);
  endfunction

  task automatic add_req(deqd_pkg::kind_t kind, deqd_pkg::value_t value);
    req_t q;
    q.kind  = kind;
    q.value = value;
    req_pending.push_back(q);
  endtask

  function automatic deqd_pkg::kind_t pick_push();
    return $urandom_range(0, 1) ? deqd_pkg::KIND_PUSH_FRONT : deqd_pkg::KIND_PUSH_BACK;
  endfunction

  function automatic deqd_pkg::kind_t pick_pop();
    return $urandom_range(0, 1) ? deqd_pkg::KIND_POP_FRONT : deqd_pkg::KIND_POP_BACK;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping between driver, responder and monitor
  // ---------------------------------------------------------------------------
  int  total_reqs = 0;
  int  accepted   = 0;   // requests taken by the block
  int  resp_seen  = 0;   // responses taken from the block
  int  errors     = 0;
  int  cycle_cnt  = 0;
  bit  req_taken  = 1'b0;  // set at the edge that accepted the request on the bus
  bit  quiet      = 1'b0;  // last stretch of the run: no idling on either side
  int  src_gap    = 0;
  int  dst_gap    = 0;
  int  hold_left  = 0;
  bit  held_once  = 1'b0;
  req_t nxt_req;

  // Request driver: holds a request until it is accepted, idles in bursts.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !req_taken) begin
      // request still on offer; keep it stable
    end else begin
      req_taken = 1'b0;
      if (src_gap != 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (req_pending.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        // idle burst of random length, this one included
        src_gap = $urandom_range(0, 17);
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt_req = req_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt_req.value;
        s_axis_tuser  <= nxt_req.kind;
      end
    end
  end

  // Response sink: random stalls, plus one long hold-off so the block backs up
  // and stops taking requests while the driver keeps offering.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!held_once && resp_seen >= 500) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (dst_gap != 0) begin
      dst_gap--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      dst_gap = $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted request, check each accepted response
  // against the oldest outstanding prediction.
  always @(posedge clk) begin
    resp_t want;
    resp_t got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        resp_due.push_back(predict_response(s_axis_tuser, s_axis_tdata));
        req_taken = 1'b1;
        accepted++;
        if (total_reqs - accepted < 120)
          quiet = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        resp_seen++;
        got.popped = m_axis_tdata[deqd_pkg::VALUE_W-1:0];
        got.count  = m_axis_tdata[deqd_pkg::VALUE_W +: CNT_W];
        got.status = m_axis_tuser;
        if (resp_due.size() == 0) begin
          errors++;
          $display("%0t: response with none outstanding: popped %h status %0d count %0d",
                   $time, got.popped, got.status, got.count);
        end else begin
          want = resp_due.pop_front();
          if (got.popped !== want.popped) begin
            errors++;
            $display("%0t: popped mismatch, expected %h got %h",
                     $time, want.popped, got.popped);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, got.status);
          end
          if (got.count !== want.count) begin
            errors++;
            $display("%0t: count mismatch, expected %0d got %0d",
                     $time, want.count, got.count);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the request list, reset, wait for the drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    int mode;
    int target;

    // Directed: empty-queue cases, unused kinds, extreme words, delete positions.
    add_req(deqd_pkg::KIND_POP_BACK,   32'hFFFF_FFFF);  // pop back on empty
    add_req(deqd_pkg::KIND_POP_FRONT,  32'h0000_0000);  // pop front on empty
    add_req(deqd_pkg::KIND_DELETE,     32'h0000_0000);  // delete on empty
    add_req(deqd_pkg::kind_t'(5),      32'hFFFF_FFFF);  // unused kinds: no operation
    add_req(deqd_pkg::kind_t'(6),      32'h0000_0000);
    add_req(deqd_pkg::kind_t'(7),      32'hA5A5_5A5A);
    add_req(deqd_pkg::KIND_PUSH_BACK,  32'h7FFF_FFFF);
    add_req(deqd_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
    add_req(deqd_pkg::KIND_PUSH_BACK,  32'h0000_0000);
    add_req(deqd_pkg::KIND_PUSH_BACK,  32'hFFFF_FFFF);
    add_req(deqd_pkg::KIND_PUSH_BACK,  32'h8000_0000);  // duplicate of the front word
    add_req(deqd_pkg::kind_t'(7),      32'h1234_5678);  // unused kind, non-empty queue
    add_req(deqd_pkg::KIND_DELETE,     32'h8000_0000);  // match at the front, first of two
    add_req(deqd_pkg::KIND_DELETE,     32'h1234_5678);  // no match
    add_req(deqd_pkg::KIND_DELETE,     32'h8000_0000);  // match at the back
    add_req(deqd_pkg::KIND_DELETE,     32'h0000_0000);  // match in the middle
    add_req(deqd_pkg::KIND_POP_FRONT,  32'h0000_0000);
    add_req(deqd_pkg::KIND_POP_BACK,   32'h0000_0000);
    add_req(deqd_pkg::KIND_POP_BACK,   32'h0000_0000);  // empty again
    add_req(deqd_pkg::KIND_PUSH_FRONT, 32'h0000_0001);
    add_req(deqd_pkg::KIND_DELETE,     32'h0000_0001);  // delete the only entry
    add_req(deqd_pkg::KIND_PUSH_BACK,  32'h5555_5555);
    add_req(deqd_pkg::KIND_PUSH_FRONT, 32'hAAAA_AAAA);
    add_req(deqd_pkg::KIND_POP_FRONT,  32'hFFFF_FFFF);
    add_req(deqd_pkg::KIND_POP_FRONT,  32'h0000_0000);

    // Random: runs of fills (to full and past it), drains, delete-heavy mixes
    // and a little noise with unused kinds.
    target = req_pending.size() + N_RANDOM;
    while (req_pending.size() < target) begin
      mode = $urandom_range(0, 9);
      case (mode)
        0, 1, 2: begin
          n = $urandom_range(20, 80);
          repeat (n) add_req(pick_push(), pick_value(1));
        end
        3, 4: begin
          n = $urandom_range(20, 80);
          repeat (n) add_req(pick_pop(), deqd_pkg::value_t'($urandom));
        end
        5, 6: begin
          n = $urandom_range(10, 30);
          repeat (n) begin
            case ($urandom_range(0, 4))
              0, 1: add_req(pick_push(), pick_value(3));
              2:    add_req(pick_pop(), deqd_pkg::value_t'($urandom));
              default: add_req(deqd_pkg::KIND_DELETE, pick_value(3));
            endcase
          end
        end
        7: begin
          n = $urandom_range(5, 20);
          repeat (n) add_req(deqd_pkg::KIND_DELETE, pick_value(3));
        end
        default: begin
          n = $urandom_range(5, 15);
          repeat (n) add_req(deqd_pkg::kind_t'($urandom_range(0, 7)),
                             deqd_pkg::value_t'($urandom));
        end
      endcase
    end
    total_reqs = req_pending.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every request taken and every response back, then let the block settle
    while (accepted != total_reqs || resp_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (resp_due.size() != 0) begin
      errors++;
      $display("%0t: %0d responses never arrived", $time, resp_due.size());
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
